// ===== hdl/assert_macros.svh =====
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication from one cycle to the next, outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/itag_pkg.sv =====
`default_nettype none

package itag_pkg;

   localparam int SRC_W       = 20;
   localparam int DST_W       = 21;
   localparam int STRIDE_W    = 16;
   localparam int TAPS_W      = 5;
   localparam int ROW_W       = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam int ROWS_PER_FRAME = 32;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS_PER_FRAME - 1);

   // position queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAPS           = 3'd0,
      CSR_TAP_DST_STRIDE = 3'd1,
      CSR_ROW_DST_STRIDE = 3'd2,
      CSR_BASE_OFFSET    = 3'd3,
      CSR_OUTER_STEP     = 3'd4,
      CSR_INNER_STEP     = 3'd5,
      CSR_TAP_SRC_STEP   = 3'd6,
      CSR_INNER_LIMIT    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [TAPS_W-1:0]   taps;
      logic [STRIDE_W-1:0] tap_dst_stride;
      logic [STRIDE_W-1:0] row_dst_stride;
      logic [SRC_W-1:0]    base_offset;
      logic [SRC_W-1:0]    outer_step;
      logic [SRC_W-1:0]    inner_step;
      logic [SRC_W-1:0]    tap_src_step;
      logic [SRC_W-1:0]    inner_limit;
   } cfg_type;

   // register file after reset: one tap, everything else zero
   localparam cfg_type CFG_RESET = '{
      taps:           TAPS_W'(1),
      tap_dst_stride: '0,
      row_dst_stride: '0,
      base_offset:    '0,
      outer_step:     '0,
      inner_step:     '0,
      tap_src_step:   '0,
      inner_limit:    '0
   };

   // one output position as handed from front to back
   typedef struct packed {
      logic [SRC_W-1:0]  src_base;
      logic [DST_W-1:0]  dst_base;
      logic [TAPS_W-1:0] count;
      logic              last_row;
   } desc_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_RUN  = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/itag_front.sv =====
`default_nettype none

module itag_front #(
   parameter int MAX_TAPS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire itag_pkg::cfg_type cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_restart,
   input  wire                  queue_full,
   output logic                 push,
   output itag_pkg::desc_type   desc
);

   logic [itag_pkg::SRC_W-1:0]  outer_ff, outer_in, outer_cur;
   logic [itag_pkg::SRC_W-1:0]  inner_ff, inner_in, inner_cur, inner_sum;
   logic [itag_pkg::ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [itag_pkg::TAPS_W-1:0] n_sat;
   logic                        accept;

   always_comb begin
      accept    = req_valid && !queue_full;
      req_ready = !queue_full;

      // restart clears the terms before this position
      outer_cur = req_restart ? '0 : outer_ff;
      inner_cur = req_restart ? '0 : inner_ff;
      row_cur   = req_restart ? '0 : row_ff;

      n_sat = (32'(cfg.taps) > MAX_TAPS) ? itag_pkg::TAPS_W'(MAX_TAPS) : cfg.taps;

      desc.src_base = outer_cur + inner_cur + cfg.base_offset;
      desc.dst_base = itag_pkg::DST_W'(row_cur) * itag_pkg::DST_W'(cfg.row_dst_stride);
      desc.count    = n_sat;
      desc.last_row = (row_cur == itag_pkg::ROW_LAST);

      // zero taps: position advances but nothing is queued
      push = accept && (n_sat != '0);

      inner_sum = inner_cur + cfg.inner_step;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      row_in    = row_ff;
      if (accept) begin
         row_in = row_cur + 1'b1;
         if (inner_sum >= cfg.inner_limit) begin
            inner_in = '0;
            outer_in = outer_cur + cfg.outer_step;
         end else begin
            inner_in = inner_sum;
            outer_in = outer_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff <= '0;
         inner_ff <= '0;
         row_ff   <= '0;
      end else begin
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         row_ff   <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/itag_queue.sv =====
`default_nettype none

`include "assert_macros.svh"

module itag_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  wire itag_pkg::desc_type push_data,
   input  wire                 pop,
   output itag_pkg::desc_type  pop_data,
   output logic                full,
   output logic                not_empty
);

   itag_pkg::desc_type                 mem_ff [itag_pkg::QUEUE_DEPTH];
   logic [itag_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [itag_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [itag_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               ptr_match;
   logic                               count_at_end;

   always_comb begin
      full      = (count_ff == itag_pkg::QUEUE_CNT_W'(itag_pkg::QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];

      // pointers meet only when empty or full
      ptr_match    = (wr_ptr_ff == rd_ptr_ff);
      count_at_end = (count_ff == '0) || full;

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_CLK(a_queue_bound, clock, reset, count_ff <= itag_pkg::QUEUE_CNT_W'(itag_pkg::QUEUE_DEPTH))
   `ASSERT_CLK(a_queue_ptr_gap, clock, reset, count_at_end == ptr_match)

endmodule

`default_nettype wire

// ===== hdl/itag_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module itag_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire itag_pkg::cfg_type             cfg,
   input  wire                                desc_valid,
   input  wire itag_pkg::desc_type            desc,
   output logic                               desc_pop,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [itag_pkg::SRC_W-1:0]         rsp_src_index,
   output logic [itag_pkg::DST_W-1:0]         rsp_dst_index,
   output logic                               rsp_last_tap,
   output logic                               rsp_frame_done
);

   itag_pkg::back_state_type          state_ff, state_in;
   logic [itag_pkg::SRC_W-1:0]        src_ff, src_in;
   logic [itag_pkg::DST_W-1:0]        dst_ff, dst_in;
   logic [itag_pkg::TAPS_W-1:0]       tap_ff, tap_in;
   logic [itag_pkg::TAPS_W-1:0]       n_ff, n_in;
   logic                              last_row_ff, last_row_in;
   logic                              out_valid_ff, out_valid_in;
   logic [itag_pkg::SRC_W-1:0]        out_src_ff, out_src_in;
   logic [itag_pkg::DST_W-1:0]        out_dst_ff, out_dst_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_frame_ff, out_frame_in;
   logic                              emit;
   logic                              is_last;
   logic                              tap_in_range;

   always_comb begin
      emit         = (state_ff == itag_pkg::BACK_RUN) && (!out_valid_ff || rsp_ready);
      is_last      = ((tap_ff + 1'b1) == n_ff);
      tap_in_range = (n_ff != '0) && (tap_ff < n_ff);

      state_in = state_ff;
      desc_pop = 1'b0;
      case (state_ff)
         itag_pkg::BACK_IDLE: begin
            if (desc_valid) begin
               desc_pop = 1'b1;
               state_in = itag_pkg::BACK_RUN;
            end
         end
         itag_pkg::BACK_RUN: begin
            // next position loads behind the last tap without a gap
            if (emit && is_last) begin
               desc_pop = desc_valid;
               state_in = desc_valid ? itag_pkg::BACK_RUN : itag_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = itag_pkg::BACK_IDLE;
         end
      endcase

      src_in      = src_ff;
      dst_in      = dst_ff;
      tap_in      = tap_ff;
      n_in        = n_ff;
      last_row_in = last_row_ff;
      if (desc_pop) begin
         src_in      = desc.src_base;
         dst_in      = desc.dst_base;
         tap_in      = '0;
         n_in        = desc.count;
         last_row_in = desc.last_row;
      end else if (emit) begin
         src_in = src_ff + cfg.tap_src_step;
         dst_in = dst_ff + itag_pkg::DST_W'(cfg.tap_dst_stride);
         tap_in = tap_ff + 1'b1;
      end

      out_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_src_in   = emit ? src_ff : out_src_ff;
      out_dst_in   = emit ? dst_ff : out_dst_ff;
      out_last_in  = emit ? is_last : out_last_ff;
      out_frame_in = emit ? (is_last && last_row_ff) : out_frame_ff;

      rsp_valid      = out_valid_ff;
      rsp_src_index  = out_src_ff;
      rsp_dst_index  = out_dst_ff;
      rsp_last_tap   = out_last_ff;
      rsp_frame_done = out_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itag_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      tap_ff       <= tap_in;
      n_ff         <= n_in;
      last_row_ff  <= last_row_in;
      out_src_ff   <= out_src_in;
      out_dst_ff   <= out_dst_in;
      out_last_ff  <= out_last_in;
      out_frame_ff <= out_frame_in;
   end

   `ASSERT_CLK(a_run_has_taps, clock, reset, state_ff != itag_pkg::BACK_RUN || tap_in_range)
   `ASSERT_NEXT(a_mid_tap_keeps_run, clock, reset, emit && !is_last, state_ff == itag_pkg::BACK_RUN)

endmodule

`default_nettype wire

// ===== hdl/im2col_tap_address_generator.sv =====
`default_nettype none

// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// request  | req_valid req_ready req_restart         | in
// response | rsp_valid rsp_ready rsp_src_index       | out
//          | rsp_dst_index rsp_last_tap rsp_frame_done |
// csr      | csr_we csr_index csr_wdata              | in
//
// each request transaction yields min(taps, MAX_TAPS) responses, one per unstalled cycle
// positions stream back to back at one tap per cycle unless stalled (back-end tap walker)
// a position with zero taps is taken by the front end and yields no response
// front end takes a request whenever the two-entry position queue has room
// synchronous active-high reset clears position terms, queue and output register
// csr registers reset to zero except taps, which resets to one

module im2col_tap_address_generator #(
   parameter int MAX_TAPS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire                                    req_restart,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [itag_pkg::SRC_W-1:0]             rsp_src_index,
   output logic [itag_pkg::DST_W-1:0]             rsp_dst_index,
   output logic                                   rsp_last_tap,
   output logic                                   rsp_frame_done,
   input  wire                                    csr_we,
   input  wire  [itag_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [itag_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // configuration registers
   itag_pkg::cfg_type   cfg_ff, cfg_in;

   // front to queue
   logic                push;
   itag_pkg::desc_type  push_desc;
   logic                queue_full;

   // queue to back
   logic                pop;
   itag_pkg::desc_type  pop_desc;
   logic                queue_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (itag_pkg::csr_reg_type'(csr_index))
            itag_pkg::CSR_TAPS:
               cfg_in.taps = csr_wdata[itag_pkg::TAPS_W-1:0];
            itag_pkg::CSR_TAP_DST_STRIDE:
               cfg_in.tap_dst_stride = csr_wdata[itag_pkg::STRIDE_W-1:0];
            itag_pkg::CSR_ROW_DST_STRIDE:
               cfg_in.row_dst_stride = csr_wdata[itag_pkg::STRIDE_W-1:0];
            itag_pkg::CSR_BASE_OFFSET:
               cfg_in.base_offset = csr_wdata[itag_pkg::SRC_W-1:0];
            itag_pkg::CSR_OUTER_STEP:
               cfg_in.outer_step = csr_wdata[itag_pkg::SRC_W-1:0];
            itag_pkg::CSR_INNER_STEP:
               cfg_in.inner_step = csr_wdata[itag_pkg::SRC_W-1:0];
            itag_pkg::CSR_TAP_SRC_STEP:
               cfg_in.tap_src_step = csr_wdata[itag_pkg::SRC_W-1:0];
            itag_pkg::CSR_INNER_LIMIT:
               cfg_in.inner_limit = csr_wdata[itag_pkg::SRC_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= itag_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: restart handling, position bases, term advance
   itag_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .queue_full  (queue_full),
      .push        (push),
      .desc        (push_desc)
   );

   // decouples position bookkeeping from the tap walk
   itag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .pop_data  (pop_desc),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   // back: walks taps, one response per cycle into the output register unless stalled
   itag_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .desc_valid     (queue_not_empty),
      .desc           (pop_desc),
      .desc_pop       (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_src_index  (rsp_src_index),
      .rsp_dst_index  (rsp_dst_index),
      .rsp_last_tap   (rsp_last_tap),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

// ===== tb/gather_move_checker.sv =====
module gather_move_checker #(
   parameter int MAX_TAPS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  wire                              req_restart,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  wire  [itag_pkg::SRC_W-1:0]       rsp_src_index,
   input  wire  [itag_pkg::DST_W-1:0]       rsp_dst_index,
   input  wire                              rsp_last_tap,
   input  wire                              rsp_frame_done,
   input  wire                              csr_we,
   input  wire  [itag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [itag_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               moves_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [itag_pkg::SRC_W-1:0] src_index;
      logic [itag_pkg::DST_W-1:0] dst_index;
      logic                       last_tap;
      logic                       frame_done;
   } gather_move_type;

   // shadow of the register file
   logic [itag_pkg::TAPS_W-1:0]   taps;
   logic [itag_pkg::STRIDE_W-1:0] tap_dst_stride;
   logic [itag_pkg::STRIDE_W-1:0] row_dst_stride;
   logic [itag_pkg::SRC_W-1:0]    base_offset;
   logic [itag_pkg::SRC_W-1:0]    outer_step;
   logic [itag_pkg::SRC_W-1:0]    inner_step;
   logic [itag_pkg::SRC_W-1:0]    tap_src_step;
   logic [itag_pkg::SRC_W-1:0]    inner_limit;

   // position walk state
   logic [itag_pkg::SRC_W-1:0]    outer_term;
   logic [itag_pkg::SRC_W-1:0]    inner_term;
   logic [itag_pkg::ROW_W-1:0]    row_in_frame;

   gather_move_type expected_moves[$];
   int              error_total = 0;

   task automatic predict_position(input logic restart);
      logic [itag_pkg::SRC_W-1:0]  tap_offset;
      logic [itag_pkg::DST_W-1:0]  dst;
      logic [itag_pkg::TAPS_W-1:0] count;
      gather_move_type             move;
      if (restart) begin
         outer_term   = '0;
         inner_term   = '0;
         row_in_frame = '0;
      end
      count      = (taps > MAX_TAPS) ? itag_pkg::TAPS_W'(MAX_TAPS) : taps;
      tap_offset = '0;
      dst        = itag_pkg::DST_W'(row_in_frame) * itag_pkg::DST_W'(row_dst_stride);
      for (int r = 0; r < count; r++) begin
         move.src_index  = outer_term + inner_term + tap_offset + base_offset;
         move.dst_index  = dst;
         move.last_tap   = (r + 1 == count);
         move.frame_done = move.last_tap && (row_in_frame == itag_pkg::ROW_LAST);
         expected_moves.insert(expected_moves.size(), move);
         dst        = dst + itag_pkg::DST_W'(tap_dst_stride);
         tap_offset = tap_offset + tap_src_step;
      end
      row_in_frame = row_in_frame + 1'b1;
      inner_term   = inner_term + inner_step;
      if (inner_term >= inner_limit) begin
         inner_term = '0;
         outer_term = outer_term + outer_step;
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      gather_move_type move;
      if (reset) begin
         taps           = itag_pkg::TAPS_W'(1);
         tap_dst_stride = '0;
         row_dst_stride = '0;
         base_offset    = '0;
         outer_step     = '0;
         inner_step     = '0;
         tap_src_step   = '0;
         inner_limit    = '0;
         outer_term     = '0;
         inner_term     = '0;
         row_in_frame   = '0;
         expected_moves.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               itag_pkg::CSR_TAPS:
                  taps = csr_wdata[itag_pkg::TAPS_W-1:0];
               itag_pkg::CSR_TAP_DST_STRIDE:
                  tap_dst_stride = csr_wdata[itag_pkg::STRIDE_W-1:0];
               itag_pkg::CSR_ROW_DST_STRIDE:
                  row_dst_stride = csr_wdata[itag_pkg::STRIDE_W-1:0];
               itag_pkg::CSR_BASE_OFFSET:
                  base_offset = csr_wdata[itag_pkg::SRC_W-1:0];
               itag_pkg::CSR_OUTER_STEP:
                  outer_step = csr_wdata[itag_pkg::SRC_W-1:0];
               itag_pkg::CSR_INNER_STEP:
                  inner_step = csr_wdata[itag_pkg::SRC_W-1:0];
               itag_pkg::CSR_TAP_SRC_STEP:
                  tap_src_step = csr_wdata[itag_pkg::SRC_W-1:0];
               itag_pkg::CSR_INNER_LIMIT:
                  inner_limit = csr_wdata[itag_pkg::SRC_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_position(req_restart);
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %s %0h %0h %0b %0b",
                        $time, "src dst last frame", rsp_src_index, rsp_dst_index,
                        rsp_last_tap, rsp_frame_done);
               error_total++;
            end else begin
               move = expected_moves.pop_front();
               check_field("src_index", 32'(move.src_index), 32'(rsp_src_index));
               check_field("dst_index", 32'(move.dst_index), 32'(rsp_dst_index));
               check_field("last_tap", 32'(move.last_tap), 32'(rsp_last_tap));
               check_field("frame_done", 32'(move.frame_done), 32'(rsp_frame_done));
            end
         end
      end
      mismatch_count <= error_total;
      moves_pending  <= expected_moves.size();
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TAPS    = 16;
   localparam int CYCLE_LIMIT = 600000;
   // cycles to let pass after the last response, covers positions with no taps
   localparam int SETTLE_CYCLES = 16;

   logic                             clock;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_restart = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [itag_pkg::SRC_W-1:0]       rsp_src_index;
   logic [itag_pkg::DST_W-1:0]       rsp_dst_index;
   logic                             rsp_last_tap;
   logic                             rsp_frame_done;
   logic                             csr_we    = 1'b0;
   logic [itag_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [itag_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int moves_pending;
   int cycle_count;

   // idle percentages for the request and response sides
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   im2col_tap_address_generator #(.MAX_TAPS(MAX_TAPS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_src_index  (rsp_src_index),
      .rsp_dst_index  (rsp_dst_index),
      .rsp_last_tap   (rsp_last_tap),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   gather_move_checker #(.MAX_TAPS(MAX_TAPS)) move_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_src_index  (rsp_src_index),
      .rsp_dst_index  (rsp_dst_index),
      .rsp_last_tap   (rsp_last_tap),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .moves_pending  (moves_pending)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: a hung or silent block ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // one request transaction; valid is only lowered when a gap is taken, so it
   // never drops and rises within the same step
   task automatic send_position(input logic restart);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait until every predicted move has come back,
   // then let the block settle so no zero-tap position is still in flight
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (moves_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write every register; unused upper data bits carry noise
   task automatic apply_config(input itag_pkg::cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= itag_pkg::CSR_TAPS;
      csr_wdata <= {15'($urandom()), c.taps};
      @(posedge clock);
      csr_index <= itag_pkg::CSR_TAP_DST_STRIDE;
      csr_wdata <= {4'($urandom()), c.tap_dst_stride};
      @(posedge clock);
      csr_index <= itag_pkg::CSR_ROW_DST_STRIDE;
      csr_wdata <= {4'($urandom()), c.row_dst_stride};
      @(posedge clock);
      csr_index <= itag_pkg::CSR_BASE_OFFSET;
      csr_wdata <= c.base_offset;
      @(posedge clock);
      csr_index <= itag_pkg::CSR_OUTER_STEP;
      csr_wdata <= c.outer_step;
      @(posedge clock);
      csr_index <= itag_pkg::CSR_INNER_STEP;
      csr_wdata <= c.inner_step;
      @(posedge clock);
      csr_index <= itag_pkg::CSR_TAP_SRC_STEP;
      csr_wdata <= c.tap_src_step;
      @(posedge clock);
      csr_index <= itag_pkg::CSR_INNER_LIMIT;
      csr_wdata <= c.inner_limit;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // registers are only touched once the block is idle
   task automatic reconfigure(input itag_pkg::cfg_type c);
      wait_quiet();
      apply_config(c);
   endtask

   function automatic itag_pkg::cfg_type random_setting();
      itag_pkg::cfg_type c;
      int                pick;
      // mostly legal tap counts, now and then zero or above the maximum
      pick = $urandom_range(19);
      if (pick == 0)
         c.taps = '0;
      else if (pick == 1)
         c.taps = itag_pkg::TAPS_W'($urandom_range(31, MAX_TAPS + 1));
      else
         c.taps = itag_pkg::TAPS_W'($urandom_range(MAX_TAPS, 1));
      c.tap_dst_stride = $urandom_range(1) ? itag_pkg::STRIDE_W'($urandom())
                                           : itag_pkg::STRIDE_W'($urandom_range(8));
      c.row_dst_stride = $urandom_range(1) ? itag_pkg::STRIDE_W'($urandom())
                                           : itag_pkg::STRIDE_W'($urandom_range(64));
      c.base_offset    = itag_pkg::SRC_W'($urandom());
      c.outer_step     = itag_pkg::SRC_W'($urandom());
      c.inner_step     = $urandom_range(1) ? itag_pkg::SRC_W'($urandom_range(16))
                                           : itag_pkg::SRC_W'($urandom());
      c.tap_src_step   = $urandom_range(1) ? itag_pkg::SRC_W'($urandom_range(64))
                                           : itag_pkg::SRC_W'($urandom());
      // small limits make the inner term wrap often, zero wraps every position
      case ($urandom_range(3))
         0:       c.inner_limit = '0;
         1:       c.inner_limit = itag_pkg::SRC_W'($urandom());
         default: c.inner_limit = itag_pkg::SRC_W'($urandom_range(200));
      endcase
      return c;
   endfunction

   // random positions in chunks, each chunk under a fresh register setting
   task automatic run_random(input int count);
      int sent;
      int chunk;
      sent = 0;
      while (sent < count) begin
         reconfigure(random_setting());
         chunk = $urandom_range(30, 12);
         for (int i = 0; i < chunk && sent < count; i++) begin
            // rare restarts so that full 32-row frames complete
            send_position($urandom_range(39) == 0);
            sent++;
            // occasional hold-off until all moves are back, mid setting
            if (i == chunk / 2 && $urandom_range(3) == 0)
               wait_quiet();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles a quarter of the time, receiver more than half
      send_idle_pct = 25;
      recv_idle_pct = 55;

      // reset values: one tap, everything else zero
      send_position(1'b1);
      send_position(1'b0);
      send_position(1'b0);

      // every register but taps at its top value, taps at 16; source index wraps
      reconfigure(itag_pkg::cfg_type'{5'd16, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF,
                                      20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
      send_position(1'b1);
      repeat (3) send_position(1'b0);

      // zero taps: no moves, but the walk still advances
      reconfigure(itag_pkg::cfg_type'{5'd0, 16'd3, 16'd5, 20'd7, 20'd11, 20'd2, 20'd1,
                                      20'd9});
      repeat (3) send_position(1'b0);

      // tap counts above the maximum saturate
      reconfigure(itag_pkg::cfg_type'{5'd31, 16'd1, 16'd100, 20'd0, 20'd4, 20'd3, 20'd2,
                                      20'd40});
      repeat (2) send_position(1'b0);
      reconfigure(itag_pkg::cfg_type'{5'd17, 16'hFFFF, 16'd1, 20'd5, 20'd1, 20'd1,
                                      20'hFFFFF, 20'd8});
      repeat (2) send_position(1'b0);

      // zero inner limit: wrap after every position
      reconfigure(itag_pkg::cfg_type'{5'd4, 16'd2, 16'd16, 20'd0, 20'd3, 20'd5, 20'd2,
                                      20'd0});
      send_position(1'b1);
      repeat (2) send_position(1'b0);

      // limit already below the step: wraps on the first compare
      reconfigure(itag_pkg::cfg_type'{5'd4, 16'd2, 16'd16, 20'd100, 20'd9, 20'd7, 20'd1,
                                      20'd3});
      repeat (3) send_position(1'b0);

      run_random(90);

      // phase two: roles swapped
      send_idle_pct = 55;
      recv_idle_pct = 25;
      run_random(90);

      // phase three: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(90);

      wait_quiet();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/itag_pkg.sv
hdl/itag_front.sv
hdl/itag_queue.sv
hdl/itag_back.sv
hdl/im2col_tap_address_generator.sv
tb/gather_move_checker.sv
tb/tb_top.sv
